FILE: hw/rtl/fir9_pkg.sv
// ----------------------------------------------------------------------------
// fir9_pkg: shared types and constants for the 9-tap FIR filter
// Widths, reset coefficients, sequencer state type and tap-to-coefficient map.
// ----------------------------------------------------------------------------
package fir9_pkg;

    localparam int DELAY_DEPTH = 8;
    localparam int NUM_TAPS    = DELAY_DEPTH + 1;
    localparam int NUM_COEFS   = 5;
    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int ACC_W       = 36;
    localparam int FRAC_BITS   = 15;
    localparam int TAP_CNT_W   = 4;
    localparam int DLY_IDX_W   = 3;
    localparam int COEF_IDX_W  = 3;
    localparam int CFG_IDX_W   = 3;

    localparam logic [TAP_CNT_W-1:0] LAST_TAP = TAP_CNT_W'(NUM_TAPS - 1);
    localparam logic [TAP_CNT_W-1:0] CENTER_TAP = TAP_CNT_W'(NUM_COEFS - 1);

    localparam logic signed [ACC_W-1:0] FULL_SCALE_POS = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] FULL_SCALE_NEG = -ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] TRUNC_BIAS     = ACC_W'((1 << FRAC_BITS) - 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_OUTER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_THIRD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_FOURTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER = 3'd4;

    localparam logic signed [SAMPLE_W-1:0] COEF_OUTER_RST  = 16'sd0;
    localparam logic signed [SAMPLE_W-1:0] COEF_SECOND_RST = -16'sd743;
    localparam logic signed [SAMPLE_W-1:0] COEF_THIRD_RST  = 16'sd0;
    localparam logic signed [SAMPLE_W-1:0] COEF_FOURTH_RST = 16'sd8978;
    localparam logic signed [SAMPLE_W-1:0] COEF_CENTER_RST = 16'sd16298;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    // symmetric taps share coefficients mirrored about the center
    function automatic logic [COEF_IDX_W-1:0] tap_coef_idx(input logic [TAP_CNT_W-1:0] tap);
        logic [TAP_CNT_W-1:0] m;
        begin
            m = (tap <= CENTER_TAP) ? tap : (LAST_TAP - tap);
            return m[COEF_IDX_W-1:0];
        end
    endfunction

endpackage

FILE: hw/rtl/fir_lowpass_9tap_saturating.sv
// ----------------------------------------------------------------------------
// fir_lowpass_9tap_saturating: 9-tap symmetric FIR low-pass, Q15 in/out
// One shared 16x16 multiply-accumulate walks the taps, then truncates
// toward zero and saturates the result to +/-32767.
// ----------------------------------------------------------------------------
// An input transaction runs the MAC over each tap, then drain, then finish, which
//   saturates, loads m_valid once any earlier result is taken, and returns to idle.
// s_ready only in idle: one transaction at a time; output reg holds one result.
// Reset: synchronous active-low aresetn clears the delay line, the sequencer
//   and the output valid, and loads the default coefficients.
module fir_lowpass_9tap_saturating (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [fir9_pkg::SAMPLE_W-1:0]  s_left_sample,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [fir9_pkg::SAMPLE_W-1:0]  m_filtered_sample,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [fir9_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [fir9_pkg::SAMPLE_W-1:0]  cfg_data
);

    fir9_pkg::state_t state_reg, state_next;

    logic        [fir9_pkg::TAP_CNT_W-1:0] tap_cnt_reg, tap_cnt_next;
    logic signed [fir9_pkg::SAMPLE_W-1:0]  x_reg, x_next;
    logic signed [fir9_pkg::SAMPLE_W-1:0]  dly_reg [fir9_pkg::DELAY_DEPTH];
    logic signed [fir9_pkg::SAMPLE_W-1:0]  coef_reg [fir9_pkg::NUM_COEFS];
    logic signed [fir9_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic signed [fir9_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic                                  m_valid_reg, m_valid_next;
    logic signed [fir9_pkg::SAMPLE_W-1:0]  out_reg, out_next;

    logic        [fir9_pkg::TAP_CNT_W-1:0] tap_m1;
    logic signed [fir9_pkg::SAMPLE_W-1:0]  tap_sample;
    logic signed [fir9_pkg::SAMPLE_W-1:0]  tap_coef;
    logic signed [fir9_pkg::ACC_W-1:0]     prod_ext;
    logic signed [fir9_pkg::ACC_W-1:0]     acc_biased;
    logic signed [fir9_pkg::ACC_W-1:0]     acc_q;
    logic signed [fir9_pkg::SAMPLE_W-1:0]  sat_val;
    logic                                  in_xact;
    logic                                  out_load;
    logic                                  dly_shift;

    assign s_ready           = aresetn && (state_reg == fir9_pkg::ST_IDLE);
    assign cfg_ready         = aresetn;
    assign m_valid           = m_valid_reg;
    assign m_filtered_sample = out_reg;
    assign in_xact           = s_valid && s_ready;

    // shared MAC operands
    assign tap_m1     = tap_cnt_reg - fir9_pkg::TAP_CNT_W'(1);
    assign tap_sample = (tap_cnt_reg == '0) ? x_reg
                                            : dly_reg[tap_m1[fir9_pkg::DLY_IDX_W-1:0]];
    assign tap_coef   = coef_reg[fir9_pkg::tap_coef_idx(tap_cnt_reg)];
    assign prod_ext   = {{(fir9_pkg::ACC_W - fir9_pkg::PROD_W){prod_reg[fir9_pkg::PROD_W-1]}},
                         prod_reg};

    // truncate toward zero, then clamp
    assign acc_biased = acc_reg[fir9_pkg::ACC_W-1] ? (acc_reg + fir9_pkg::TRUNC_BIAS) : acc_reg;
    assign acc_q      = acc_biased >>> fir9_pkg::FRAC_BITS;

    always_comb begin
        priority if (acc_q > fir9_pkg::FULL_SCALE_POS) begin
            sat_val = fir9_pkg::SAMPLE_W'(fir9_pkg::FULL_SCALE_POS);
        end else if (acc_q < fir9_pkg::FULL_SCALE_NEG) begin
            sat_val = fir9_pkg::SAMPLE_W'(fir9_pkg::FULL_SCALE_NEG);
        end else begin
            sat_val = acc_q[fir9_pkg::SAMPLE_W-1:0];
        end
    end

    always_comb begin
        state_next   = state_reg;
        tap_cnt_next = tap_cnt_reg;
        x_next       = x_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out_load     = 1'b0;
        dly_shift    = 1'b0;

        unique case (state_reg)
            fir9_pkg::ST_IDLE: begin
                if (in_xact) begin
                    x_next       = s_left_sample;
                    tap_cnt_next = '0;
                    state_next   = fir9_pkg::ST_MAC;
                end
            end
            fir9_pkg::ST_MAC: begin
                prod_next = tap_sample * tap_coef;
                acc_next  = (tap_cnt_reg == '0) ? '0 : (acc_reg + prod_ext);
                if (tap_cnt_reg == fir9_pkg::LAST_TAP) begin
                    state_next = fir9_pkg::ST_DRAIN;
                end else begin
                    tap_cnt_next = tap_cnt_reg + fir9_pkg::TAP_CNT_W'(1);
                end
            end
            fir9_pkg::ST_DRAIN: begin
                acc_next   = acc_reg + prod_ext;
                dly_shift  = 1'b1;
                state_next = fir9_pkg::ST_FIN;
            end
            fir9_pkg::ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    out_next     = sat_val;
                    m_valid_next = 1'b1;
                    state_next   = fir9_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fir9_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        out_reg  <= out_next;
        if (!aresetn) begin
            state_reg   <= fir9_pkg::ST_IDLE;
            tap_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < fir9_pkg::DELAY_DEPTH; i++) begin
                dly_reg[i] <= '0;
            end
            coef_reg[0] <= fir9_pkg::COEF_OUTER_RST;
            coef_reg[1] <= fir9_pkg::COEF_SECOND_RST;
            coef_reg[2] <= fir9_pkg::COEF_THIRD_RST;
            coef_reg[3] <= fir9_pkg::COEF_FOURTH_RST;
            coef_reg[4] <= fir9_pkg::COEF_CENTER_RST;
        end else begin
            state_reg   <= state_next;
            tap_cnt_reg <= tap_cnt_next;
            m_valid_reg <= m_valid_next;
            if (dly_shift) begin
                dly_reg[0] <= x_reg;
                for (int i = 1; i < fir9_pkg::DELAY_DEPTH; i++) begin
                    dly_reg[i] <= dly_reg[i-1];
                end
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    fir9_pkg::REG_COEF_OUTER:  coef_reg[0] <= cfg_data;
                    fir9_pkg::REG_COEF_SECOND: coef_reg[1] <= cfg_data;
                    fir9_pkg::REG_COEF_THIRD:  coef_reg[2] <= cfg_data;
                    fir9_pkg::REG_COEF_FOURTH: coef_reg[3] <= cfg_data;
                    fir9_pkg::REG_COEF_CENTER: coef_reg[4] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

`ifndef ASSERT_OFF
    a_tap_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tap_cnt_reg <= fir9_pkg::LAST_TAP)
        else $error("tap counter out of range");

    a_start_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xact |=> (state_reg == fir9_pkg::ST_MAC) && (tap_cnt_reg == '0))
        else $error("input transaction did not start the MAC sequence");

    a_fin_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fir9_pkg::ST_FIN) && m_valid_reg && !m_ready
        |=> (state_reg == fir9_pkg::ST_FIN) && $stable(out_reg))
        else $error("pending result overwritten");

    a_no_min_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_filtered_sample != -16'sd32768))
        else $error("saturation produced the most negative code");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg)
        else $error("result loaded without valid");
`endif

endmodule
